// ===== rtl/core/wpwa_pkg.sv =====
`timescale 1ns / 1ps

package wpwa_pkg;

   // Widths of the fixed item fields and of the internal sums.
   localparam int unsigned COORD_W  = 8;
   localparam int unsigned WT_W     = 16;
   localparam int unsigned PIX_W    = 8;
   localparam int unsigned AVG_W    = 16;
   localparam int unsigned PWT_W    = 2 * WT_W;             // UQ2.30 pixel weight
   localparam int unsigned PROD_W   = PWT_W + PIX_W;        // weight times intensity
   localparam int unsigned SUMW_W   = PWT_W + 2 * COORD_W;  // total weight
   localparam int unsigned SUMI_W   = PROD_W + 2 * COORD_W; // weighted intensity
   localparam int unsigned CMP_W    = 13;                   // holds any image extent
   localparam int unsigned DIV_CNT_W = 4;

   localparam logic [WT_W-1:0]      WT_ONE   = 16'd32768;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = 4'd15;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_FETCH  = 6'b000010,
      ST_MULT   = 6'b000100,
      ST_ACCUM  = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

endpackage

// ===== rtl/core/weighted_pixel_window_average_unit.sv =====
`timescale 1ns / 1ps
// A pixel write gives no result word and leaves the unit ready. A query walks the window
// pixels in turn, each through a store read with weight multiply, an intensity multiply
// and an accumulate, then runs a one-bit-per-cycle restoring divider and loads the result
// word; no new request is taken until the word is loaded. Zero total weight skips the
// divider, an empty window goes straight to the result word, and a stalled result word
// holds the unit. Reset (synchronous) clears the sequencer and result valid.

module weighted_pixel_window_average_unit #(
   parameter int unsigned IMG_ROWS = 256,
   parameter int unsigned IMG_COLS = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [wpwa_pkg::COORD_W-1:0]  req_row_first,
   input  logic [wpwa_pkg::COORD_W-1:0]  req_row_last,
   input  logic [wpwa_pkg::COORD_W-1:0]  req_col_first,
   input  logic [wpwa_pkg::COORD_W-1:0]  req_col_last,
   input  logic [wpwa_pkg::WT_W-1:0]     req_wt_row_first,
   input  logic [wpwa_pkg::WT_W-1:0]     req_wt_row_last,
   input  logic [wpwa_pkg::WT_W-1:0]     req_wt_col_first,
   input  logic [wpwa_pkg::WT_W-1:0]     req_wt_col_last,
   input  logic [wpwa_pkg::PIX_W-1:0]    req_pixel_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [wpwa_pkg::AVG_W-1:0]    rsp_average,
   output logic                          rsp_has_weight
);
   import wpwa_pkg::*;

   // The store is addressed linearly, row major.
   localparam int unsigned DEPTH  = IMG_ROWS * IMG_COLS;
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned AXW    = ADDR_W + COORD_W;

   logic [PIX_W-1:0] pixel_mem [DEPTH];

   state_type state_ff, state_in;

   // Query window, clamped to the image, and its edge weights.
   logic [COORD_W-1:0] r1_ff, r2_ff, c1_ff, c2_ff;
   logic [WT_W-1:0]    wr1_ff, wr2_ff, wc1_ff, wc2_ff;
   logic [COORD_W-1:0] row_ff, col_ff;
   logic [ADDR_W-1:0]  row_base_ff;

   logic [PIX_W-1:0]   pix_ff;
   logic [PWT_W-1:0]   w_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [SUMI_W-1:0]  sum_int_ff;
   logic [SUMW_W-1:0]  sum_wt_ff;

   logic [SUMW_W-1:0]    div_rem_ff;
   logic [AVG_W-1:0]     div_low_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;

   logic             rsp_valid_ff;
   logic [AVG_W-1:0] rsp_average_ff;
   logic             rsp_has_weight_ff;

   logic               req_take;
   logic [COORD_W-1:0] r1_clamp, r2_clamp, c1_clamp, c2_clamp;
   logic               wr_in_image;
   logic [ADDR_W-1:0]  wr_addr, rd_addr, base_start;
   logic [WT_W-1:0]    row_wt, col_wt;
   logic               last_col, last_row;
   logic [SUMW_W:0]    div_trial, div_diff;
   logic               div_fits;
   logic               rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // A window bound beyond the image is pulled back to its last row or column.
   // When the image is wider than a coordinate can reach, the clamp never fires.
   always_comb begin
      r1_clamp = req_row_first;
      r2_clamp = req_row_last;
      c1_clamp = req_col_first;
      c2_clamp = req_col_last;
      if (CMP_W'(req_row_first) >= CMP_W'(IMG_ROWS)) r1_clamp = COORD_W'(IMG_ROWS - 1);
      if (CMP_W'(req_row_last)  >= CMP_W'(IMG_ROWS)) r2_clamp = COORD_W'(IMG_ROWS - 1);
      if (CMP_W'(req_col_first) >= CMP_W'(IMG_COLS)) c1_clamp = COORD_W'(IMG_COLS - 1);
      if (CMP_W'(req_col_last)  >= CMP_W'(IMG_COLS)) c2_clamp = COORD_W'(IMG_COLS - 1);
   end

   // Writes outside the image are dropped.
   assign wr_in_image = (CMP_W'(req_row_first) < CMP_W'(IMG_ROWS)) &&
                        (CMP_W'(req_col_first) < CMP_W'(IMG_COLS));
   assign wr_addr    = ADDR_W'(AXW'(req_row_first) * AXW'(IMG_COLS) + AXW'(req_col_first));
   assign base_start = ADDR_W'(AXW'(r1_clamp) * AXW'(IMG_COLS));
   assign rd_addr    = ADDR_W'(AXW'(row_base_ff) + AXW'(col_ff));

   // The first row or column wins over the last one when they coincide.
   always_comb begin
      if (row_ff == r1_ff) begin
         row_wt = wr1_ff;
      end else if (row_ff == r2_ff) begin
         row_wt = wr2_ff;
      end else begin
         row_wt = WT_ONE;
      end
      if (col_ff == c1_ff) begin
         col_wt = wc1_ff;
      end else if (col_ff == c2_ff) begin
         col_wt = wc2_ff;
      end else begin
         col_wt = WT_ONE;
      end
   end

   assign last_col = (col_ff == c2_ff);
   assign last_row = (row_ff == r2_ff);

   // Restoring divider: one quotient bit per cycle. The quotient is known to fit in
   // sixteen bits, so the partial remainder always stays below the total weight.
   assign div_trial = {div_rem_ff, div_low_ff[AVG_W-1]};
   assign div_diff  = div_trial - {1'b0, sum_wt_ff};
   assign div_fits  = !div_diff[SUMW_W];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_mode == MODE_QUERY)) begin
               if ((r1_clamp <= r2_clamp) && (c1_clamp <= c2_clamp)) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FETCH: state_in = ST_MULT;
         ST_MULT:  state_in = ST_ACCUM;
         ST_ACCUM: begin
            if (last_col && last_row) begin
               // Zero total weight skips the divider.
               if ((sum_wt_ff + SUMW_W'(w_ff)) == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_DIV;
               end
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_DIV: begin
            if (div_cnt_ff == '0) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Pixel store: a write port fed from the request and a registered read port.
   always_ff @(posedge clock) begin
      if (req_take && (req_mode == MODE_WRITE) && wr_in_image) begin
         pixel_mem[wr_addr] <= req_pixel_value;
      end
      if (state_ff == ST_FETCH) begin
         pix_ff <= pixel_mem[rd_addr];
      end
   end

   // Query data path.
   always_ff @(posedge clock) begin
      if (req_take) begin
         r1_ff       <= r1_clamp;
         r2_ff       <= r2_clamp;
         c1_ff       <= c1_clamp;
         c2_ff       <= c2_clamp;
         wr1_ff      <= req_wt_row_first;
         wr2_ff      <= req_wt_row_last;
         wc1_ff      <= req_wt_col_first;
         wc2_ff      <= req_wt_col_last;
         row_ff      <= r1_clamp;
         col_ff      <= c1_clamp;
         row_base_ff <= base_start;
         sum_int_ff  <= '0;
         sum_wt_ff   <= '0;
      end
      case (state_ff)
         ST_FETCH: begin
            w_ff <= PWT_W'(row_wt) * PWT_W'(col_wt);
         end
         ST_MULT: begin
            prod_ff <= PROD_W'(w_ff) * PROD_W'(pix_ff);
         end
         ST_ACCUM: begin
            sum_int_ff <= sum_int_ff + SUMI_W'(prod_ff);
            sum_wt_ff  <= sum_wt_ff + SUMW_W'(w_ff);
            if (last_col) begin
               col_ff      <= c1_ff;
               row_ff      <= row_ff + COORD_W'(1);
               row_base_ff <= ADDR_W'(AXW'(row_base_ff) + AXW'(IMG_COLS));
            end else begin
               col_ff <= col_ff + COORD_W'(1);
            end
            // The dividend is 256 times the weighted sum; its top part seeds the remainder.
            if (last_col && last_row) begin
               {div_rem_ff, div_low_ff} <= {sum_int_ff + SUMI_W'(prod_ff), 8'd0};
               div_cnt_ff <= DIV_LAST;
            end
         end
         ST_DIV: begin
            if (div_fits) begin
               div_rem_ff <= div_diff[SUMW_W-1:0];
            end else begin
               div_rem_ff <= div_trial[SUMW_W-1:0];
            end
            div_low_ff <= {div_low_ff[AVG_W-2:0], div_fits};
            div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   // Output register. An empty window or zero total weight reports zero without weight.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_FINISH) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_FINISH) && rsp_free) begin
         if (sum_wt_ff != '0) begin
            rsp_average_ff    <= div_low_ff;
            rsp_has_weight_ff <= 1'b1;
         end else begin
            rsp_average_ff    <= '0;
            rsp_has_weight_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_average    = rsp_average_ff;
   assign rsp_has_weight = rsp_has_weight_ff;

endmodule

// ===== rtl/core/wpwa_checker.sv =====
`timescale 1ns / 1ps

module wpwa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_mode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_average,
   input logic        rsp_has_weight
);
   import wpwa_pkg::*;

   // A result word that is not taken holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average) && $stable(rsp_has_weight))
      else $error("result word changed while stalled");

   // A window without weight reports a zero average.
   a_no_weight_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_weight |-> rsp_average == '0)
      else $error("nonzero average without weight");

   // A weighted mean of bytes never exceeds 255.0 in UQ8.8.
   a_avg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_average <= 16'd65280)
      else $error("average out of range");

   // A query keeps the unit busy in the next cycle.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == MODE_QUERY) |=> !req_ready)
      else $error("ready right after a query");

   // A pixel write never produces a result word.
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == MODE_WRITE) && !rsp_valid |=> !rsp_valid)
      else $error("result word after a pixel write");

endmodule

bind weighted_pixel_window_average_unit wpwa_checker u_wpwa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_mode       (req_mode),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_average    (rsp_average),
   .rsp_has_weight (rsp_has_weight)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import wpwa_pkg::*;

   // The slowest legal word is a 12 x 12 query, delayed further by a receiver stall
   // and a sender gap. The limit is taken with ample margin over that worst case.
   localparam int QUIET_LIMIT = 4000;
   // Total number of words to send, directed part included.
   localparam int WORD_TARGET = 650;
   // From this word count on, neither side idles.
   localparam int CALM_FROM   = 550;
   // Cycles to wait after the last expected word, so that a stray word shows up.
   localparam int TAIL_CYCLES = 40;

   // One request word together with an optional expected result. A result is
   // pinned only where it can be read straight off the behavior; every other
   // query is checked against the predictor below.
   typedef struct {
      logic        mode;
      logic [7:0]  row_first;
      logic [7:0]  row_last;
      logic [7:0]  col_first;
      logic [7:0]  col_last;
      logic [15:0] wt_row_first;
      logic [15:0] wt_row_last;
      logic [15:0] wt_col_first;
      logic [15:0] wt_col_last;
      logic [7:0]  pixel_value;
      bit          pinned;
      logic [15:0] pinned_average;
      logic        pinned_has_weight;
   } stim_type;

   // The fields of one result word.
   typedef struct packed {
      logic [15:0] average;
      logic        has_weight;
   } mean_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_mode;
   logic [7:0]  req_row_first;
   logic [7:0]  req_row_last;
   logic [7:0]  req_col_first;
   logic [7:0]  req_col_last;
   logic [15:0] req_wt_row_first;
   logic [15:0] req_wt_row_last;
   logic [15:0] req_wt_col_first;
   logic [15:0] req_wt_col_last;
   logic [7:0]  req_pixel_value;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_average;
   logic        rsp_has_weight;

   // The pinned expectation travels with the word on the request side, so that
   // the monitor picks it up at the same edge at which the word is taken.
   bit          word_pinned;
   logic [15:0] word_pinned_average;
   logic        word_pinned_has_weight;

   // Our own copy of the image, updated as write words are taken.
   logic [7:0] shadow_image [0:65535];
   // Which pixels the stimulus has already written; queries stay on these.
   bit         pixel_known  [0:65535];
   // Means still owed by the block, oldest first.
   mean_type   pending_means[$];

   stim_type   opening_words[$];
   bit         idling_on;
   int         stall_left;
   int         words_sent;
   int         mismatches;
   int         quiet_cycles;
   int         writes_taken;
   int         queries_taken;
   int         weighted_seen;
   bit         took_word;
   mean_type   due;

   always #1 clock = ~clock;

   weighted_pixel_window_average_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_row_first    (req_row_first),
      .req_row_last     (req_row_last),
      .req_col_first    (req_col_first),
      .req_col_last     (req_col_last),
      .req_wt_row_first (req_wt_row_first),
      .req_wt_row_last  (req_wt_row_last),
      .req_wt_col_first (req_wt_col_first),
      .req_wt_col_last  (req_wt_col_last),
      .req_pixel_value  (req_pixel_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_average      (rsp_average),
      .rsp_has_weight   (rsp_has_weight)
   );

   // Weighted mean of a window over the shadow image. Each pixel weight is the
   // exact UQ2.30 product of a row weight and a column weight. The first row
   // or column takes its first weight, the last one its last weight, and any
   // row or column in between weighs one. A window of one row or one column
   // therefore takes the first weight only. The quotient is floored to UQ8.8
   // in two steps, integer part then fraction, so that nothing overflows.
   function automatic mean_type weighted_mean(input logic [7:0] rf, input logic [7:0] rl,
                                              input logic [7:0] cf, input logic [7:0] cl,
                                              input logic [15:0] wrf, input logic [15:0] wrl,
                                              input logic [15:0] wcf, input logic [15:0] wcl);
      longint unsigned sum_int;
      longint unsigned sum_wt;
      longint unsigned rw;
      longint unsigned cw;
      longint unsigned pw;
      longint unsigned quo;
      longint unsigned rem;
      int              r;
      int              c;
      mean_type        m;
      sum_int = 0;
      sum_wt  = 0;
      if (rf <= rl && cf <= cl) begin
         for (r = int'(rf); r <= int'(rl); r++) begin
            rw = (r == int'(rf)) ? longint'(wrf) :
                 (r == int'(rl)) ? longint'(wrl) : longint'(WT_ONE);
            for (c = int'(cf); c <= int'(cl); c++) begin
               cw = (c == int'(cf)) ? longint'(wcf) :
                    (c == int'(cl)) ? longint'(wcl) : longint'(WT_ONE);
               pw = rw * cw;
               sum_int += pw * longint'(shadow_image[r * 256 + c]);
               sum_wt  += pw;
            end
         end
      end
      m.average    = 16'd0;
      m.has_weight = 1'b0;
      if (sum_wt != 0) begin
         quo          = sum_int / sum_wt;
         rem          = sum_int % sum_wt;
         m.average    = 16'(quo * 256 + (rem * 256) / sum_wt);
         m.has_weight = 1'b1;
      end
      return m;
   endfunction

   // A write word. The window bounds and weights mean nothing to a write, so
   // they get random values to show that the block ignores them.
   function automatic stim_type pixel_write(input int r, input int c, input int v);
      stim_type w;
      w.mode              = MODE_WRITE;
      w.row_first         = 8'(r);
      w.col_first         = 8'(c);
      w.pixel_value       = 8'(v);
      w.row_last          = 8'($urandom);
      w.col_last          = 8'($urandom);
      w.wt_row_first      = 16'($urandom);
      w.wt_row_last       = 16'($urandom);
      w.wt_col_first      = 16'($urandom);
      w.wt_col_last       = 16'($urandom);
      w.pinned            = 1'b0;
      w.pinned_average    = 16'd0;
      w.pinned_has_weight = 1'b0;
      return w;
   endfunction

   // A query word; the pixel value is a don't-care and is randomized.
   function automatic stim_type window_query(input int rf, input int rl, input int cf, input int cl,
                                             input logic [15:0] wrf, input logic [15:0] wrl,
                                             input logic [15:0] wcf, input logic [15:0] wcl,
                                             input bit pin = 1'b0, input int pin_avg = 0,
                                             input bit pin_hw = 1'b0);
      stim_type w;
      w.mode              = MODE_QUERY;
      w.row_first         = 8'(rf);
      w.row_last          = 8'(rl);
      w.col_first         = 8'(cf);
      w.col_last          = 8'(cl);
      w.wt_row_first      = wrf;
      w.wt_row_last       = wrl;
      w.wt_col_first      = wcf;
      w.wt_col_last       = wcl;
      w.pixel_value       = 8'($urandom);
      w.pinned            = pin;
      w.pinned_average    = 16'(pin_avg);
      w.pinned_has_weight = pin_hw;
      return w;
   endfunction

   // Weights lean toward zero, one and the top of the range, since those are
   // where the arithmetic has its corners.
   function automatic logic [15:0] pick_weight_value();
      case ($urandom_range(0, 7))
         0:       return 16'd0;
         1:       return WT_ONE;
         2:       return 16'hFFFF;
         3:       return 16'($urandom_range(0, 32768));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Drive one word and hold it until the block takes it. With idling on, the
   // sender sometimes drops valid for a burst first. Valid is raised at the
   // falling edge, never lowered and raised in the same step.
   task automatic send_word(input stim_type w);
      int gap;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid              <= 1'b1;
      req_mode               <= w.mode;
      req_row_first          <= w.row_first;
      req_row_last           <= w.row_last;
      req_col_first          <= w.col_first;
      req_col_last           <= w.col_last;
      req_wt_row_first       <= w.wt_row_first;
      req_wt_row_last        <= w.wt_row_last;
      req_wt_col_first       <= w.wt_col_first;
      req_wt_col_last        <= w.wt_col_last;
      req_pixel_value        <= w.pixel_value;
      word_pinned            <= w.pinned;
      word_pinned_average    <= w.pinned_average;
      word_pinned_has_weight <= w.pinned_has_weight;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   // Stop sending and wait until every mean owed has come back.
   task automatic drain_pending();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
   endtask

   // Receiver: while idling is on, rsp_ready drops for random bursts.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 13);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor, sampling at the rising edge. A result word is checked before a
   // new query word is predicted, since the block finishes one query before it
   // takes the next. Write words update the shadow image as they are taken.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         took_word = 1'b0;
         if (rsp_valid && rsp_ready) begin
            took_word = 1'b1;
            if (rsp_has_weight === 1'b1) weighted_seen++;
            if (pending_means.size() == 0) begin
               note_mismatch($sformatf("result word avg=%0d flag=%0b with no query waiting",
                                       rsp_average, rsp_has_weight));
            end else begin
               due = pending_means.pop_front();
               if (rsp_average !== due.average) begin
                  note_mismatch($sformatf("average %0d, wanted %0d", rsp_average, due.average));
               end
               if (rsp_has_weight !== due.has_weight) begin
                  note_mismatch($sformatf("has_weight %0b, wanted %0b",
                                          rsp_has_weight, due.has_weight));
               end
            end
         end
         if (req_valid && req_ready) begin
            took_word = 1'b1;
            if (req_mode == MODE_WRITE) begin
               writes_taken++;
               shadow_image[int'(req_row_first) * 256 + int'(req_col_first)] = req_pixel_value;
            end else begin
               queries_taken++;
               if (word_pinned) begin
                  due.average    = word_pinned_average;
                  due.has_weight = word_pinned_has_weight;
               end else begin
                  due = weighted_mean(req_row_first, req_row_last, req_col_first, req_col_last,
                                      req_wt_row_first, req_wt_row_last,
                                      req_wt_col_first, req_wt_col_last);
               end
               pending_means.push_back(due);
            end
         end
         // Watchdog: too long with no word moving on either side ends the run.
         quiet_cycles = took_word ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles, %0d means owed",
                     QUIET_LIMIT, pending_means.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      int       pick;
      int       h;
      int       wd;
      int       r0;
      int       c0;
      int       r;
      int       c;
      int       a;
      int       b;
      int       d;
      int       e;
      stim_type w;

      reset                  = 1'b1;
      req_valid              = 1'b0;
      req_mode               = MODE_WRITE;
      req_row_first          = 8'd0;
      req_row_last           = 8'd0;
      req_col_first          = 8'd0;
      req_col_last           = 8'd0;
      req_wt_row_first       = 16'd0;
      req_wt_row_last        = 16'd0;
      req_wt_col_first       = 16'd0;
      req_wt_col_last        = 16'd0;
      req_pixel_value        = 8'd0;
      word_pinned            = 1'b0;
      word_pinned_average    = 16'd0;
      word_pinned_has_weight = 1'b0;
      idling_on              = 1'b1;
      stall_left             = 0;
      words_sent             = 0;
      mismatches             = 0;
      writes_taken           = 0;
      queries_taken          = 0;
      weighted_seen          = 0;

      // Directed part. A small patch at the top left corner and the far corner
      // pixel are written first, so that every query below reads only pixels
      // that hold a value.
      opening_words.push_back(pixel_write(0, 0, 0));
      opening_words.push_back(pixel_write(0, 1, 255));
      opening_words.push_back(pixel_write(1, 0, 255));
      opening_words.push_back(pixel_write(1, 1, 128));
      opening_words.push_back(pixel_write(255, 255, 255));
      opening_words.push_back(pixel_write(0, 2, 17));
      opening_words.push_back(pixel_write(1, 2, 200));
      opening_words.push_back(pixel_write(2, 0, 99));
      opening_words.push_back(pixel_write(2, 1, 1));
      opening_words.push_back(pixel_write(2, 2, 254));
      // Single dark pixel, and single bright pixel at the last row and column.
      opening_words.push_back(window_query(0, 0, 0, 0, WT_ONE, WT_ONE, WT_ONE, WT_ONE,
                                           1'b1, 0, 1'b1));
      opening_words.push_back(window_query(255, 255, 255, 255, WT_ONE, WT_ONE, WT_ONE, WT_ONE,
                                           1'b1, 65280, 1'b1));
      // Zero total weight: the only row weighs nothing.
      opening_words.push_back(window_query(0, 0, 0, 0, 16'd0, WT_ONE, WT_ONE, WT_ONE,
                                           1'b1, 0, 1'b0));
      // Empty windows, first by rows and then by columns.
      opening_words.push_back(window_query(255, 0, 0, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                           16'hFFFF, 1'b1, 0, 1'b0));
      opening_words.push_back(window_query(0, 255, 1, 0, WT_ONE, WT_ONE, WT_ONE, WT_ONE,
                                           1'b1, 0, 1'b0));
      // Plain mean, weights above one, a weightless first row.
      opening_words.push_back(window_query(0, 1, 0, 1, WT_ONE, WT_ONE, WT_ONE, WT_ONE));
      opening_words.push_back(window_query(0, 1, 0, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      opening_words.push_back(window_query(0, 1, 0, 1, 16'd0, WT_ONE, WT_ONE, WT_ONE));
      // One row only: the row takes its first weight, never its last.
      opening_words.push_back(window_query(0, 0, 0, 1, WT_ONE, 16'd0, WT_ONE, WT_ONE));
      // Three by three, so the middle pixel weighs one.
      opening_words.push_back(window_query(0, 2, 0, 2, 16'd1000, 16'd20000, 16'hFFFF, 16'd7));
      opening_words.push_back(window_query(0, 2, 0, 2, WT_ONE, WT_ONE, WT_ONE, WT_ONE));
      // Overwrite the far corner with zero and read it back.
      opening_words.push_back(pixel_write(255, 255, 0));
      opening_words.push_back(window_query(255, 255, 255, 255, WT_ONE, WT_ONE, WT_ONE, WT_ONE,
                                           1'b1, 0, 1'b1));

      repeat (11) @(negedge clock);
      reset = 1'b0;

      foreach (opening_words[i]) begin
         w = opening_words[i];
         if (w.mode == MODE_WRITE) begin
            pixel_known[int'(w.row_first) * 256 + int'(w.col_first)] = 1'b1;
         end
         send_word(w);
      end
      // Let the block run dry once before the random part starts.
      drain_pending();

      // Random part. Most of it is well formed: the pixels of a small window are
      // written first where needed, then the window is queried. The rest is
      // stray writes anywhere in the image and queries of empty windows.
      while (words_sent < WORD_TARGET) begin
         if (words_sent >= CALM_FROM) begin
            idling_on = 1'b0;
         end else begin
            if ($urandom_range(0, 9) == 0) idling_on = !idling_on;
            if ($urandom_range(0, 29) == 0) drain_pending();
         end
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            if ($urandom_range(0, 49) == 0) begin
               h  = $urandom_range(5, 12);
               wd = $urandom_range(5, 12);
            end else begin
               h  = $urandom_range(1, 4);
               wd = $urandom_range(1, 4);
            end
            r0 = $urandom_range(0, 256 - h);
            c0 = $urandom_range(0, 256 - wd);
            for (r = r0; r < r0 + h; r++) begin
               for (c = c0; c < c0 + wd; c++) begin
                  if (!pixel_known[r * 256 + c] || $urandom_range(0, 3) == 0) begin
                     pixel_known[r * 256 + c] = 1'b1;
                     send_word(pixel_write(r, c, $urandom_range(0, 255)));
                  end
               end
            end
            send_word(window_query(r0, r0 + h - 1, c0, c0 + wd - 1,
                                   pick_weight_value(), pick_weight_value(),
                                   pick_weight_value(), pick_weight_value()));
         end else if (pick < 17) begin
            r = $urandom_range(0, 255);
            c = $urandom_range(0, 255);
            pixel_known[r * 256 + c] = 1'b1;
            send_word(pixel_write(r, c, $urandom_range(0, 255)));
         end else begin
            // Empty window: first above last on one axis, anything on the other.
            a = $urandom_range(1, 255);
            b = $urandom_range(0, a - 1);
            d = $urandom_range(0, 255);
            e = $urandom_range(0, 255);
            if ($urandom_range(0, 1) == 0) begin
               send_word(window_query(a, b, d, e, pick_weight_value(), pick_weight_value(),
                                      pick_weight_value(), pick_weight_value()));
            end else begin
               send_word(window_query(d, e, a, b, pick_weight_value(), pick_weight_value(),
                                      pick_weight_value(), pick_weight_value()));
            end
         end
      end

      drain_pending();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d pixel writes and %0d window queries, %0d of them weighted",
               writes_taken, queries_taken, weighted_seen);
      $display("%0d mismatches found", mismatches);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/wpwa_pkg.sv
rtl/core/weighted_pixel_window_average_unit.sv
rtl/core/wpwa_checker.sv
dv/testbench.sv
